@@ rtl/core/efjd_pkg.sv @@
// package for the earliest finish job dispatcher
// holds word types, mode codes, sequencer states and default sizes; no dependencies
`default_nettype none

package efjd_pkg;

    localparam int DEF_MAX_MACHINES = 32;
    localparam int DEF_MAX_JOBS     = 1024;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 5;
    localparam int DUR_W  = 8;
    localparam int TIME_W = 18;
    localparam int CFG_W  = 6;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [CFG_W-1:0]  CFG_RESET = 6'd1;

    localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  machine_index;
        logic [DUR_W-1:0]  job_duration;
    } t_efjd_in;

    typedef struct packed {
        logic [IDX_W-1:0]  chosen_machine;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] makespan;
    } t_efjd_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_efjd_state;

endpackage

`default_nettype wire

@@ rtl/core/efjd_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module efjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/efjd_cost_unit.sv @@
// shared cost unit: one candidate per cycle, multiply then compare against best
// depends on efjd_pkg for the duration width
`default_nettype none

module efjd_cost_unit #(
    parameter int AW = 5,
    parameter int CW = 11,
    localparam int TW = CW + efjd_pkg::DUR_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_first,
    input  wire logic [AW-1:0]               i_idx,
    input  wire logic [CW-1:0]               i_cnt,
    input  wire logic [efjd_pkg::DUR_W-1:0]  i_dur,
    output logic                             o_busy,
    output logic      [AW-1:0]               o_best_idx,
    output logic      [CW-1:0]               o_best_cnt,
    output logic      [efjd_pkg::DUR_W-1:0]  o_best_dur,
    output logic      [TW-1:0]               o_best_cost
);

    logic                       r_p_valid;
    logic                       r_p_first;
    logic [AW-1:0]              r_p_idx;
    logic [CW-1:0]              r_p_cnt;
    logic [efjd_pkg::DUR_W-1:0] r_p_dur;
    logic [TW-1:0]              r_p_cost;

    logic [AW-1:0]              r_best_idx;
    logic [CW-1:0]              r_best_cnt;
    logic [efjd_pkg::DUR_W-1:0] r_best_dur;
    logic [TW-1:0]              r_best_cost;

    logic [TW-1:0]              w_prod;

    // (count + 1) * duration
    assign w_prod = TW'(i_cnt + CW'(1)) * TW'(i_dur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
        end
        r_p_first <= i_first;
        r_p_idx   <= i_idx;
        r_p_cnt   <= i_cnt;
        r_p_dur   <= i_dur;
        r_p_cost  <= w_prod;
    end

    // strict less keeps the lowest index on a tie
    always_ff @(posedge i_clk) begin
        if (r_p_valid && (r_p_first || (r_p_cost < r_best_cost))) begin
            r_best_idx  <= r_p_idx;
            r_best_cnt  <= r_p_cnt;
            r_best_dur  <= r_p_dur;
            r_best_cost <= r_p_cost;
        end
    end

    assign o_busy      = r_p_valid;
    assign o_best_idx  = r_best_idx;
    assign o_best_cnt  = r_best_cnt;
    assign o_best_dur  = r_best_dur;
    assign o_best_cost = r_best_cost;

endmodule

`default_nettype wire

@@ rtl/core/earliest_finish_job_dispatcher.sv @@
// top level of the earliest finish job dispatcher: sequencer, tables, output register
// depends on efjd_pkg, efjd_ram and efjd_cost_unit
`default_nettype none

// Each input word is a load (sets one machine's per-job duration), a clear (zeroes all
// job counts and the makespan) or a dispatch; mode code 3 is taken and ignored.
// Loads and clears are taken while idle and give no output word. A dispatch walks the
// machines in use one per cycle through a single shared multiply/compare unit, picking
// the least (count+1)*duration with the lowest index winning ties, then bumps that
// machine's count (held at MAX_JOBS) and emits the machine, this job's finish time and
// the running makespan. After it is taken a dispatch stalls the input through the
// table reads, the drain of the read/multiply/compare pipe and the update cycle, and
// longer while the previous output word is still stalled. Durations must be loaded
// before a dispatch reads them; job counts come up cleared through per-machine valid
// bits, so no clearing pass is needed. machines_in_use is written through
// i_cfg_we/i_cfg_wdata; it must be written only while idle, which the block itself
// does not enforce; 0 acts as 1 and values above MAX_MACHINES act as MAX_MACHINES.
module earliest_finish_job_dispatcher #(
    parameter int MAX_MACHINES = efjd_pkg::DEF_MAX_MACHINES,
    parameter int MAX_JOBS     = efjd_pkg::DEF_MAX_JOBS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [efjd_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire efjd_pkg::t_efjd_in          i_in_word,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output efjd_pkg::t_efjd_out              o_out_word
);

    localparam int AW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CW = $clog2(MAX_JOBS + 2);
    localparam int TW = CW + efjd_pkg::DUR_W;
    localparam int FW = (TW > efjd_pkg::TIME_W) ? TW : efjd_pkg::TIME_W;

    efjd_pkg::t_efjd_state r_state, n_state;

    logic [efjd_pkg::CFG_W-1:0]  r_cfg;
    logic [AW-1:0]               r_scan;
    logic [AW-1:0]               r_last;
    logic [MAX_MACHINES-1:0]     r_cnt_vld;
    logic [efjd_pkg::TIME_W-1:0] r_mk;
    logic                        r_out_valid;
    efjd_pkg::t_efjd_out         r_out_word;

    // read stage tags, aligned with the registered ram data
    logic                        r_s0_v;
    logic                        r_s0_first;
    logic [AW-1:0]               r_s0_idx;
    logic                        r_s0_cntv;

    logic                        w_in_fire;
    logic                        w_load;
    logic                        w_clear;
    logic                        w_dispatch;
    logic                        w_out_free;
    logic                        w_finish;
    logic [AW-1:0]               w_last;

    logic [efjd_pkg::DUR_W-1:0]  w_dur_rdata;
    logic [CW-1:0]               w_cnt_rdata;
    logic [CW-1:0]               w_cnt_in;

    logic                        w_busy;
    logic [AW-1:0]               w_best_idx;
    logic [CW-1:0]               w_best_cnt;
    logic [efjd_pkg::DUR_W-1:0]  w_best_dur;
    logic [TW-1:0]               w_best_cost;

    logic                        w_at_limit;
    logic [CW-1:0]               w_new_cnt;
    logic [TW-1:0]               w_fin;
    logic [efjd_pkg::TIME_W-1:0] w_ft;
    logic [efjd_pkg::TIME_W-1:0] w_mk;

    // input decode
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_load     = w_in_fire && (i_in_word.mode == efjd_pkg::MODE_LOAD)
                        && (int'(i_in_word.machine_index) < MAX_MACHINES);
    assign w_clear    = w_in_fire && (i_in_word.mode == efjd_pkg::MODE_CLEAR);
    assign w_dispatch = w_in_fire && (i_in_word.mode == efjd_pkg::MODE_DISPATCH);

    // last machine index to scan, with the register clamped into range
    always_comb begin
        priority if (r_cfg == '0) begin
            w_last = '0;
        end else if (int'(r_cfg) >= MAX_MACHINES) begin
            w_last = AW'(MAX_MACHINES - 1);
        end else begin
            w_last = AW'(r_cfg - efjd_pkg::CFG_W'(1));
        end
    end

    // output register frees when empty or being taken
    assign w_out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efjd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        w_finish   = 1'b0;
        unique case (r_state)
            efjd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (w_dispatch) begin
                    n_state = efjd_pkg::ST_SCAN;
                end
            end
            efjd_pkg::ST_SCAN: begin
                if (r_scan == r_last) begin
                    n_state = efjd_pkg::ST_FINISH;
                end
            end
            efjd_pkg::ST_FINISH: begin
                // wait for the pipe to drain and room at the output
                if (!r_s0_v && !w_busy && w_out_free) begin
                    w_finish = 1'b1;
                    n_state  = efjd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = efjd_pkg::ST_IDLE;
            end
        endcase
    end

    // config register and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= efjd_pkg::CFG_RESET;
            r_s0_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_s0_v <= (r_state == efjd_pkg::ST_SCAN);
        end
        if (w_dispatch) begin
            r_scan <= '0;
            r_last <= w_last;
        end else if (r_state == efjd_pkg::ST_SCAN && r_scan != r_last) begin
            r_scan <= r_scan + AW'(1);
        end
        r_s0_first <= (r_scan == '0);
        r_s0_idx   <= r_scan;
        r_s0_cntv  <= r_cnt_vld[r_scan];
    end

    // duration table, undefined until loaded
    efjd_ram #(
        .WIDTH (efjd_pkg::DUR_W),
        .DEPTH (MAX_MACHINES)
    ) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(i_in_word.machine_index)),
        .i_wdata (i_in_word.job_duration),
        .i_raddr (r_scan),
        .o_rdata (w_dur_rdata)
    );

    // job counts; an entry without its valid bit reads as zero
    efjd_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_MACHINES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_finish),
        .i_waddr (w_best_idx),
        .i_wdata (w_new_cnt),
        .i_raddr (r_scan),
        .o_rdata (w_cnt_rdata)
    );

    assign w_cnt_in = r_s0_cntv ? w_cnt_rdata : '0;

    efjd_cost_unit #(
        .AW (AW),
        .CW (CW)
    ) u_cost (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s0_v),
        .i_first     (r_s0_first),
        .i_idx       (r_s0_idx),
        .i_cnt       (w_cnt_in),
        .i_dur       (w_dur_rdata),
        .o_busy      (w_busy),
        .o_best_idx  (w_best_idx),
        .o_best_cnt  (w_best_cnt),
        .o_best_dur  (w_best_dur),
        .o_best_cost (w_best_cost)
    );

    // finish time comes from the winning cost; at the job limit the count does not
    // move, so one duration is taken back off
    assign w_at_limit = (w_best_cnt >= CW'(MAX_JOBS));
    assign w_new_cnt  = w_at_limit ? w_best_cnt : (w_best_cnt + CW'(1));
    assign w_fin      = w_at_limit ? (w_best_cost - TW'(w_best_dur)) : w_best_cost;
    assign w_ft       = (FW'(w_fin) > FW'(efjd_pkg::TIME_MAX)) ? efjd_pkg::TIME_MAX
                                                               : efjd_pkg::TIME_W'(w_fin);
    assign w_mk       = (w_ft > r_mk) ? w_ft : r_mk;

    // valid bits, makespan and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld   <= '0;
            r_mk        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_clear) begin
                r_cnt_vld <= '0;
                r_mk      <= '0;
            end else if (w_finish) begin
                r_cnt_vld[w_best_idx] <= 1'b1;
                r_mk                  <= w_mk;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_finish) begin
            r_out_word.chosen_machine <= efjd_pkg::IDX_W'(w_best_idx);
            r_out_word.finish_time    <= w_ft;
            r_out_word.makespan       <= w_mk;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a new output word only comes out of the update cycle
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == efjd_pkg::ST_FINISH)
        else $error("output word without a finished dispatch");

    // the makespan covers the job it is reported with
    a_mk_covers_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.makespan >= o_out_word.finish_time)
        else $error("makespan below finish time");

    // the scan never passes the last machine in use
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == efjd_pkg::ST_SCAN |-> r_scan <= r_last)
        else $error("scan index beyond last machine");

    // the chosen machine's count is marked live after an update
    a_cnt_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_cnt_vld[$past(w_best_idx)])
        else $error("count valid bit not set after dispatch");

endmodule

`default_nettype wire
